/* sv/ssf_pkg.sv */
// Shared types, constants and the digit-to-segment table for the serial frame generator.
// No dependencies; every other file refers to it by scoped names.
package ssf_pkg;

    localparam int FRAME_BITS = 36;
    localparam int VALUE_W    = 12;
    localparam int SEG_W      = 8;
    localparam int PAT_W      = 3 * SEG_W;
    localparam int BIT_IDX_W  = 6;
    localparam int MAG_W      = 10;

    localparam logic signed [VALUE_W-1:0] SAT_MAX = 12'sd999;
    localparam logic signed [VALUE_W-1:0] SAT_MIN = -12'sd99;

    localparam logic [SEG_W-1:0] SEG_MINUS = 8'b00000010;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'b00000000;

    typedef logic [PAT_W-1:0] t_pattern;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Segment bits are a,b,c,d,e,f,g,dp from MSB to LSB.
    function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'b11111100;
            4'd1:    s = 8'b01100000;
            4'd2:    s = 8'b11011010;
            4'd3:    s = 8'b11110010;
            4'd4:    s = 8'b01100110;
            4'd5:    s = 8'b10110110;
            4'd6:    s = 8'b10111110;
            4'd7:    s = 8'b11100000;
            4'd8:    s = 8'b11111110;
            4'd9:    s = 8'b11110110;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

/* sv/ssf_front.sv */
// Front end: accepts a value, saturates it, splits it into decimal digits over two
// stages and pushes the three segment patterns into the queue. Uses ssf_pkg.
module ssf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ssf_pkg::VALUE_W-1:0]  i_value,
    input  ssf_pkg::t_q_status                  i_q_status,
    output logic                                o_push,
    output ssf_pkg::t_pattern                   o_push_pat
);

    logic signed [ssf_pkg::VALUE_W-1:0] sat;
    logic                               neg;
    logic [ssf_pkg::MAG_W-1:0]          mag;
    logic [15:0]                        prod_h;
    logic [17:0]                        prod_t;
    logic                               accept;

    logic                               r_a_valid, n_a_valid;
    logic                               r_neg;
    logic [3:0]                         r_h;
    logic [6:0]                         r_q10;
    logic [ssf_pkg::MAG_W-1:0]          r_mag;

    logic [3:0]                         tens;
    logic [3:0]                         units;
    logic [ssf_pkg::SEG_W-1:0]          d1, d2, d3;

    // Stage A: saturate, magnitude, and reciprocal multiplies for /100 and /10.
    always_comb begin
        if (i_value > ssf_pkg::SAT_MAX) begin
            sat = ssf_pkg::SAT_MAX;
        end else if (i_value < ssf_pkg::SAT_MIN) begin
            sat = ssf_pkg::SAT_MIN;
        end else begin
            sat = i_value;
        end
        neg    = sat[ssf_pkg::VALUE_W-1];
        mag    = neg ? ssf_pkg::MAG_W'(-sat) : ssf_pkg::MAG_W'(sat);
        // Both reciprocals are exact for magnitudes below 1000.
        prod_h = 16'(mag) * 16'd41;
        prod_t = 18'(mag) * 18'd205;
    end

    assign o_stall = r_a_valid && i_q_status.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_a_valid && !i_q_status.full;

    always_comb begin
        n_a_valid = r_a_valid;
        if (accept) begin
            n_a_valid = 1'b1;
        end else if (o_push) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= neg;
            r_h   <= prod_h[15:12];
            r_q10 <= prod_t[17:11];
            r_mag <= mag;
        end
    end

    // Stage B: remaining digits and segment lookup.
    always_comb begin
        tens  = 4'(r_q10 - 7'(r_h) * 7'd10);
        units = 4'(r_mag - ssf_pkg::MAG_W'(r_q10) * ssf_pkg::MAG_W'(10));
        d3    = ssf_pkg::seg_digit(units);
        d2    = ((r_h != 4'd0) || (tens != 4'd0)) ? ssf_pkg::seg_digit(tens)
                                                  : ssf_pkg::SEG_BLANK;
        if (r_neg) begin
            d1 = ssf_pkg::SEG_MINUS;
        end else if (r_h != 4'd0) begin
            d1 = ssf_pkg::seg_digit(r_h);
        end else begin
            d1 = ssf_pkg::SEG_BLANK;
        end
        o_push_pat = {d1, d2, d3};
    end

endmodule

/* sv/ssf_queue.sv */
// Two-entry queue of segment patterns between the front end and the serializer.
// Uses ssf_pkg for the pattern and status types.
module ssf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ssf_pkg::t_pattern   i_push_pat,
    input  logic                i_pop,
    output ssf_pkg::t_pattern   o_head,
    output ssf_pkg::t_q_status  o_status
);

    ssf_pkg::t_pattern r_mem [2];
    logic              r_wp, n_wp;
    logic              r_rp, n_rp;
    logic [1:0]        r_cnt, n_cnt;

    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_head         = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = i_pop  ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_pat;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full || i_pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not advance on a write");
`endif

endmodule

/* sv/ssf_back.sv */
// Serializer: loads a pattern from the queue and sends the frame one bit per transaction.
// Uses ssf_pkg for widths and the pattern and status types.
module ssf_back #(
    parameter int FRAME_BITS = ssf_pkg::FRAME_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssf_pkg::t_pattern               i_head,
    input  ssf_pkg::t_q_status              i_q_status,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_serial_data,
    output logic [ssf_pkg::BIT_IDX_W-1:0]   o_bit_index,
    output logic                            o_last_bit
);

    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

    logic                  r_busy, n_busy;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  out_take;
    logic                  last;
    logic [FRAME_BITS-1:0] load_word;

    assign last      = (r_idx == LAST_IDX);
    assign out_take  = r_busy && !i_stall;
    assign o_pop     = !i_q_status.empty && (!r_busy || (out_take && last));
    // Start bit, then the three patterns MSB first, then zero fill.
    assign load_word = FRAME_BITS'({1'b1, i_head}) << (FRAME_BITS - ssf_pkg::PAT_W - 1);

    always_comb begin
        n_busy  = r_busy;
        n_shift = r_shift;
        n_idx   = r_idx;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_shift = load_word;
            n_idx   = '0;
        end else if (out_take) begin
            n_shift = r_shift << 1;
            n_idx   = r_idx + IDX_W'(1);
            if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    assign o_valid       = r_busy;
    assign o_serial_data = r_shift[FRAME_BITS-1];
    assign o_bit_index   = ssf_pkg::BIT_IDX_W'(r_idx);
    assign o_last_bit    = last;

`ifndef SYNTHESIS
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_bit)
            |=> (o_valid && o_bit_index == $past(o_bit_index) + 6'd1))
        else $error("frame bit index did not advance");
    a_start_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bit_index == 6'd0) |-> o_serial_data)
        else $error("frame does not open with a start bit");
    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bit_index > 6'd24) |-> !o_serial_data)
        else $error("frame tail bit is not zero");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_bit_index)))
        else $error("frame position moved while stalled");
`endif

endmodule

/* sv/integer_to_seven_segment_serial_frame.sv */
// Top level of the three-digit seven-segment serial frame generator.
// Instantiates ssf_front, ssf_queue and ssf_back; uses ssf_pkg.
//
//   Channel  Direction  Handshake          Payload
//   input    in         i_valid / o_stall  i_value (12-bit signed)
//   result   out        o_valid / i_stall  o_serial_data, o_bit_index, o_last_bit
//
// Each value gives FRAME_BITS result transactions, one per cycle when not stalled;
// the serializer sets the sustained rate. Each accepted value is registered in
// the front stage and pushed once the queue has room; up to three values wait
// (two in the queue, one in the front stage) while a frame is being sent.
// Reset is synchronous and active low and empties the pipeline and the queue.
// o_stall rises only when the front stage is full and the queue cannot take it.
module integer_to_seven_segment_serial_frame #(
    parameter int FRAME_BITS = ssf_pkg::FRAME_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [ssf_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_serial_data,
    output logic [ssf_pkg::BIT_IDX_W-1:0]      o_bit_index,
    output logic                               o_last_bit
);

    ssf_pkg::t_q_status q_status;
    ssf_pkg::t_pattern  push_pat;
    ssf_pkg::t_pattern  head;
    logic               push;
    logic               pop;

    ssf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_pat (push_pat)
    );

    ssf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_pat (push_pat),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    ssf_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_serial_data (o_serial_data),
        .o_bit_index   (o_bit_index),
        .o_last_bit    (o_last_bit)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for integer_to_seven_segment_serial_frame: each value becomes a
// 36-bit display frame that a scoreboard predicts and checks bit by bit. Uses ssf_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_VALUES = 250;

    typedef logic signed [ssf_pkg::VALUE_W-1:0] t_value;

    typedef struct {
        logic                          serial_data;
        logic [ssf_pkg::BIT_IDX_W-1:0] bit_index;
        logic                          last_bit;
    } t_frame_bit;

    class t_frame_scoreboard;
        t_frame_bit  expected_bits[$];
        int          errors;
        int          bits_checked;
        logic [7:0]  glyph[10] = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66,
                                   8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6};

        // Works out the three segment patterns and queues the whole frame.
        function void note_value(t_value v);
            int         shown;
            int         mag;
            logic [7:0] left_seg, mid_seg, right_seg;
            logic [23:0] digits;
            t_frame_bit fb;
            shown = v;
            if (shown > 999) shown = 999;
            if (shown < -99) shown = -99;
            if (shown < 0) begin
                mag = -shown;
                left_seg  = ssf_pkg::SEG_MINUS;
                mid_seg   = (mag / 10 != 0) ? glyph[mag / 10] : ssf_pkg::SEG_BLANK;
                right_seg = glyph[mag % 10];
            end else begin
                left_seg  = (shown / 100 != 0) ? glyph[shown / 100] : ssf_pkg::SEG_BLANK;
                mid_seg   = (shown >= 10) ? glyph[(shown / 10) % 10] : ssf_pkg::SEG_BLANK;
                right_seg = glyph[shown % 10];
            end
            digits = {left_seg, mid_seg, right_seg};
            for (int k = 0; k < ssf_pkg::FRAME_BITS; k++) begin
                if (k == 0) fb.serial_data = 1'b1;
                else if (k <= 24) fb.serial_data = digits[24 - k];
                else fb.serial_data = 1'b0;
                fb.bit_index = k[ssf_pkg::BIT_IDX_W-1:0];
                fb.last_bit  = (k == ssf_pkg::FRAME_BITS - 1);
                expected_bits.push_back(fb);
            end
        endfunction

        function void check_bit(logic data, logic [ssf_pkg::BIT_IDX_W-1:0] idx, logic last);
            t_frame_bit fb;
            if (expected_bits.size() == 0) begin
                $error("unexpected result transaction: data %0b index %0d last %0b",
                       data, idx, last);
                errors++;
                return;
            end
            fb = expected_bits.pop_front();
            bits_checked++;
            if (data !== fb.serial_data) begin
                $error("serial_data: expected %0b, got %0b", fb.serial_data, data);
                errors++;
            end
            if (idx !== fb.bit_index) begin
                $error("bit_index: expected %0d, got %0d", fb.bit_index, idx);
                errors++;
            end
            if (last !== fb.last_bit) begin
                $error("last_bit: expected %0b, got %0b", fb.last_bit, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    t_value                        i_value;
    logic                          o_valid;
    logic                          i_stall;
    logic                          o_serial_data;
    logic [ssf_pkg::BIT_IDX_W-1:0] o_bit_index;
    logic                          o_last_bit;

    t_frame_scoreboard sb;
    bit  steady;
    bit  hold_req;
    int  quiet_cycles;
    int  values_sent;
    int  saturated;
    int  negatives;

    integer_to_seven_segment_serial_frame i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_serial_data (o_serial_data),
        .o_bit_index   (o_bit_index),
        .o_last_bit    (o_last_bit)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offers one value from a falling edge and returns on the falling edge after the
    // transaction; valid stays high so back-to-back values need no gap.
    task automatic offer_value(input t_value v);
        while (!steady && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        sb.note_value(v);
        values_sent++;
        if (v > 999 || v < -99) saturated++;
        if (v < 0) negatives++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Receiver side: random stalls, a calm stretch, and one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall <= !steady && ($urandom_range(99) < 14);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_bit(o_serial_data, o_bit_index, o_last_bit);
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("integer_to_seven_segment_serial_frame: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int     directed[] = '{0, 1, 9, 10, 99, 100, 101, 110, 999, 1000, 2047,
                               -1, -9, -10, -55, -99, -100, -2048, 555, 123,
                               456, 789, 806, -70, 1024};
        t_value v;
        int     pick;
        sb = new();
        steady   = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n]) offer_value(t_value'(directed[n]));
        // Let the block empty before the random part starts.
        wait_for_drain();

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            steady = (n >= 100 && n < 160);
            if (n == 40) hold_req = 1'b1;
            if (n == 200) wait_for_drain();
            pick = $urandom_range(99);
            if (pick < 70) v = t_value'($urandom_range(1098) - 99);
            else if (pick < 80) v = t_value'($urandom_range(24) - 12);
            else v = t_value'($urandom_range(4095));
            offer_value(v);
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d values framed (%0d negative, %0d beyond the display range),",
                 values_sent, negatives, saturated);
        $display("%0d frame bits compared, with random stalls and a long receiver hold-off",
                 sb.bits_checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("integer_to_seven_segment_serial_frame: match");
        else
            $display("integer_to_seven_segment_serial_frame: mismatch");
        $finish;
    end
endmodule
